// ----- sv/cst_pkg.sv -----
// shared constants, codes and helpers of the csv streaming tokenizer
package cst_pkg;

   localparam int COL_WIDTH_DEF   = 16;
   localparam int LEN_WIDTH_DEF   = 32;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;

   localparam logic [7:0] QUOTE_BYTE      = 8'h22;
   localparam logic [7:0] NEWLINE_BYTE    = 8'h0A;
   localparam logic [7:0] SEPARATOR_RESET = 8'd44;

   typedef enum logic [1:0] {
      KIND_FIELD   = 2'd0,
      KIND_SEP     = 2'd1,
      KIND_NEWLINE = 2'd2,
      KIND_ERROR   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE   = 2'd0,
      ERR_UNEVEN = 2'd1,
      ERR_QUOTE  = 2'd2
   } err_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SEPARATOR  = 1'b0,
      CSR_NULL_AWARE = 1'b1
   } csr_index_type;

   // queue entry: one flag for a second token, then two tokens of kind, size, column, error
   function automatic int entry_width(int len_w, int col_w);
      return 1 + 2 * ($bits(kind_type) + len_w + col_w + $bits(err_type));
   endfunction

endpackage

// ----- sv/cst_if.sv -----
// request, response and register-write channel interfaces
interface cst_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_stream;

   modport source (output valid, output data_byte, output end_of_stream, input ready);
   modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface cst_rsp_if #(
   parameter int LEN_WIDTH = cst_pkg::LEN_WIDTH_DEF,
   parameter int COL_WIDTH = cst_pkg::COL_WIDTH_DEF
);
   logic                 valid;
   logic                 ready;
   logic [1:0]           token_kind;
   logic [LEN_WIDTH-1:0] token_size;
   logic [COL_WIDTH-1:0] column;
   logic [1:0]           error_code;
   logic                 last_of_run;

   modport source (output valid, output token_kind, output token_size, output column,
                   output error_code, output last_of_run, input ready);
   modport sink (input valid, input token_kind, input token_size, input column,
                 input error_code, input last_of_run, output ready);
endinterface

interface cst_csr_if;
   logic                             valid;
   logic                             ready;
   logic [cst_pkg::CSR_INDEX_W-1:0]  index;
   logic [cst_pkg::CSR_DATA_W-1:0]   write_data;

   modport source (output valid, output index, output write_data, input ready);
   modport sink (input valid, input index, input write_data, output ready);
endinterface

// ----- sv/csv_streaming_tokenizer_unit.sv -----
// top level of the streaming csv tokenizer
//
// requests on req_chan carry one byte of csv text and an end-of-stream flag;
// each accepted request yields zero, one or two tokens on rsp_chan, the last
// one flagged by last_of_run. csr_chan writes the separator byte (index 0)
// and the null-aware mode bit (index 1); it is always ready. the user must
// write it only while no request is in flight; the block does not enforce it.
// timing: the front end handles a request in the cycle it is accepted and
// pushes its tokens as one group into a short queue; the back end holds the
// output register, so the first token of a request passes through the queue
// and then the output register before it is presented. one request per cycle
// is accepted while the queue is not full; the output register plays one
// token per cycle while rsp_chan is ready, and the sustained rate is one
// token per clock.
// when rsp_chan stalls, the queue fills and req_chan.ready drops once it is
// full; nothing is lost or repeated.
// reset (synchronous, active high) restores separator ',' and plain mode and
// clears the lexer state, queue and output register.
module csv_streaming_tokenizer_unit #(
   parameter int COL_WIDTH   = cst_pkg::COL_WIDTH_DEF,
   parameter int LEN_WIDTH   = cst_pkg::LEN_WIDTH_DEF,
   parameter int QUEUE_DEPTH = cst_pkg::QUEUE_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   cst_req_if.sink   req_chan,
   cst_rsp_if.source rsp_chan,
   cst_csr_if.sink   csr_chan
);
   import cst_pkg::*;

   // one queue entry holds every token a single request can cause
   localparam int ENTRY_W = entry_width(LEN_WIDTH, COL_WIDTH);

   logic               push;
   logic [ENTRY_W-1:0] push_data;
   logic               queue_full;
   logic               pop;
   logic [ENTRY_W-1:0] head_data;
   logic               queue_empty;

   // front end: register file, lexer state, token generation
   cst_front #(
      .LEN_WIDTH (LEN_WIDTH),
      .COL_WIDTH (COL_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_chan   (csr_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   // decoupling queue of token groups
   cst_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .head_data (head_data),
      .empty     (queue_empty)
   );

   // back end: output register, one token per cycle while rsp_chan is ready
   cst_back #(
      .LEN_WIDTH (LEN_WIDTH),
      .COL_WIDTH (COL_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head_data (head_data),
      .empty     (queue_empty),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ----- sv/cst_front.sv -----
// front end: lexer state, register file and token generation per request
module cst_front #(
   parameter int LEN_WIDTH = cst_pkg::LEN_WIDTH_DEF,
   parameter int COL_WIDTH = cst_pkg::COL_WIDTH_DEF,
   localparam int ENTRY_W = cst_pkg::entry_width(LEN_WIDTH, COL_WIDTH)
) (
   input  logic               clock,
   input  logic               reset,
   cst_req_if.sink            req_chan,
   cst_csr_if.sink            csr_chan,
   input  logic               queue_full,
   output logic               push,
   output logic [ENTRY_W-1:0] push_data
);
   import cst_pkg::*;

   localparam int SUM_W = ((LEN_WIDTH > COL_WIDTH) ? LEN_WIDTH : COL_WIDTH) + 1;
   localparam logic [LEN_WIDTH-1:0] LEN_MAX = '1;
   localparam logic [COL_WIDTH-1:0] COL_MAX = '1;

   typedef struct packed {
      kind_type             kind;
      logic [LEN_WIDTH-1:0] size;
      logic [COL_WIDTH-1:0] column;
      err_type              err;
   } tok_type;

   typedef struct packed {
      logic    two;
      tok_type tok1;
      tok_type tok0;
   } entry_type;

   typedef struct packed {
      logic [1:0] count;
      tok_type    tok1;
      tok_type    tok0;
   } slots_type;

   function automatic slots_type put_tok(slots_type s, tok_type t);
      slots_type r;
      r = s;
      if (s.count == 2'd0) begin
         r.tok0  = t;
         r.count = 2'd1;
      end else if (s.count == 2'd1) begin
         r.tok1  = t;
         r.count = 2'd2;
      end
      return r;
   endfunction

   function automatic tok_type mk_tok(kind_type k, logic [LEN_WIDTH-1:0] sz,
                                      logic [COL_WIDTH-1:0] col, err_type e);
      tok_type t;
      t.kind   = k;
      t.size   = sz;
      t.column = col;
      t.err    = e;
      return t;
   endfunction

   function automatic logic [LEN_WIDTH-1:0] len_inc(logic [LEN_WIDTH-1:0] x);
      return (x == LEN_MAX) ? x : x + 1'b1;
   endfunction

   function automatic logic [COL_WIDTH-1:0] col_add(logic [COL_WIDTH-1:0] c,
                                                    logic [LEN_WIDTH-1:0] a);
      logic [SUM_W-1:0] s;
      s = SUM_W'(c) + SUM_W'(a);
      return (s > SUM_W'(COL_MAX)) ? COL_MAX : s[COL_WIDTH-1:0];
   endfunction

   // registers
   logic [7:0]           sep_ff;
   logic                 na_ff;
   // lexer state
   logic                 inq_ff, inq_in;
   logic [LEN_WIDTH-1:0] flen_ff, flen_in;
   logic                 fst_ff, fst_in;
   logic [LEN_WIDTH-1:0] run_ff, run_in;
   logic [COL_WIDTH-1:0] col_ff, col_in;
   logic [COL_WIDTH:0]   cpr_ff, cpr_in;
   logic                 first_ff, first_in;
   logic                 stop_ff, stop_in;

   logic                 is_quote, is_nl, is_sep, eos;
   logic [COL_WIDTH:0]   col_plus1;
   logic                 req_acc, csr_acc;
   slots_type            slots;
   entry_type            entry;

   assign eos      = req_chan.end_of_stream;
   assign is_quote = (req_chan.data_byte == QUOTE_BYTE);
   assign is_nl    = (req_chan.data_byte == NEWLINE_BYTE);
   assign is_sep   = !is_quote && !is_nl && (req_chan.data_byte == sep_ff);

   assign req_chan.ready = !queue_full;
   assign csr_chan.ready = 1'b1;
   assign req_acc        = req_chan.valid && req_chan.ready;
   assign csr_acc        = csr_chan.valid;

   always_comb begin
      inq_in    = inq_ff;
      flen_in   = flen_ff;
      fst_in    = fst_ff;
      run_in    = run_ff;
      col_in    = col_ff;
      cpr_in    = cpr_ff;
      first_in  = first_ff;
      stop_in   = stop_ff;
      slots     = '0;
      col_plus1 = '0;

      if (!stop_ff) begin
         if (inq_ff) begin
            flen_in = len_inc(flen_ff);
            if (is_quote) begin
               inq_in = 1'b0;
            end
         end else begin
            // pending separator run goes out ahead of anything else
            if (run_ff != '0 && !(is_sep && na_ff)) begin
               slots  = put_tok(slots, mk_tok(KIND_SEP, run_ff, '0, ERR_NONE));
               col_in = col_add(col_in, run_ff);
               run_in = '0;
            end

            if (is_quote) begin
               inq_in  = 1'b1;
               fst_in  = 1'b1;
               flen_in = len_inc(flen_in);
            end else if (is_nl) begin
               if (fst_in) begin
                  slots = put_tok(slots, mk_tok(KIND_FIELD, flen_in, col_in, ERR_NONE));
               end
               flen_in   = '0;
               col_plus1 = (COL_WIDTH + 1)'(col_in) + (COL_WIDTH + 1)'(1);
               if (first_ff) begin
                  cpr_in = col_plus1;
               end
               if (col_plus1 != cpr_in) begin
                  slots   = put_tok(slots, mk_tok(KIND_ERROR, '0, '0, ERR_UNEVEN));
                  stop_in = 1'b1;
               end else begin
                  slots = put_tok(slots, mk_tok(KIND_NEWLINE, LEN_WIDTH'(1), '0, ERR_NONE));
               end
               col_in   = '0;
               first_in = 1'b0;
               fst_in   = !na_ff;
            end else if (is_sep) begin
               if (na_ff) begin
                  if (run_in != '0) begin
                     run_in = len_inc(run_in);
                  end else begin
                     if (fst_in) begin
                        slots = put_tok(slots, mk_tok(KIND_FIELD, flen_in, col_in, ERR_NONE));
                     end
                     flen_in = '0;
                     fst_in  = 1'b0;
                     run_in  = LEN_WIDTH'(1);
                  end
               end else begin
                  if (fst_in) begin
                     slots = put_tok(slots, mk_tok(KIND_FIELD, flen_in, col_in, ERR_NONE));
                  end
                  flen_in = '0;
                  slots   = put_tok(slots, mk_tok(KIND_SEP, LEN_WIDTH'(1), '0, ERR_NONE));
                  col_in  = col_add(col_in, LEN_WIDTH'(1));
                  fst_in  = 1'b1;
               end
            end else begin
               fst_in  = 1'b1;
               flen_in = len_inc(flen_in);
            end
         end

         // end of stream flush
         if (eos && !stop_in) begin
            if (inq_in) begin
               slots = put_tok(slots, mk_tok(KIND_ERROR, '0, '0, ERR_QUOTE));
            end else begin
               if (flen_in != '0) begin
                  slots = put_tok(slots, mk_tok(KIND_FIELD, flen_in, col_in, ERR_NONE));
               end
               if (run_in != '0) begin
                  slots = put_tok(slots, mk_tok(KIND_SEP, run_in, '0, ERR_NONE));
               end
            end
         end
      end

      if (eos) begin
         inq_in   = 1'b0;
         flen_in  = '0;
         fst_in   = !na_ff;
         run_in   = '0;
         col_in   = '0;
         cpr_in   = '0;
         first_in = 1'b1;
         stop_in  = 1'b0;
      end
   end

   assign entry.two  = (slots.count == 2'd2);
   assign entry.tok1 = slots.tok1;
   assign entry.tok0 = slots.tok0;
   assign push       = req_acc && (slots.count != 2'd0);
   assign push_data  = entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_ff   <= SEPARATOR_RESET;
         na_ff    <= 1'b0;
         inq_ff   <= 1'b0;
         flen_ff  <= '0;
         fst_ff   <= 1'b1;
         run_ff   <= '0;
         col_ff   <= '0;
         cpr_ff   <= '0;
         first_ff <= 1'b1;
         stop_ff  <= 1'b0;
      end else begin
         if (req_acc) begin
            inq_ff   <= inq_in;
            flen_ff  <= flen_in;
            fst_ff   <= fst_in;
            run_ff   <= run_in;
            col_ff   <= col_in;
            cpr_ff   <= cpr_in;
            first_ff <= first_in;
            stop_ff  <= stop_in;
         end
         if (csr_acc) begin
            unique case (csr_index_type'(csr_chan.index))
               CSR_SEPARATOR: begin
                  sep_ff <= csr_chan.write_data;
               end
               CSR_NULL_AWARE: begin
                  na_ff <= csr_chan.write_data[0];
                  // mode switch only rearms the field when nothing is pending
                  if (flen_ff == '0 && run_ff == '0 && !inq_ff) begin
                     fst_ff <= !csr_chan.write_data[0];
                  end
               end
            endcase
         end
      end
   end

   a_silent_after_error: assert property (@(posedge clock) disable iff (reset)
      (req_acc && stop_ff && !eos) |-> !push)
      else $error("token produced while stopped on error");

   a_restart_on_eos: assert property (@(posedge clock) disable iff (reset)
      (req_acc && eos && !csr_acc) |=> (first_ff && !stop_ff && !inq_ff && run_ff == '0))
      else $error("lexer state not restarted after end of stream");

endmodule

// ----- sv/cst_queue.sv -----
// small register queue of token groups between front and back end
module cst_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = cst_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign head_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("pop from empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

endmodule

// ----- sv/cst_back.sv -----
// back end: output register that plays out each token group one token at a time
module cst_back #(
   parameter int LEN_WIDTH = cst_pkg::LEN_WIDTH_DEF,
   parameter int COL_WIDTH = cst_pkg::COL_WIDTH_DEF,
   localparam int ENTRY_W = cst_pkg::entry_width(LEN_WIDTH, COL_WIDTH)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [ENTRY_W-1:0] head_data,
   input  logic               empty,
   output logic               pop,
   cst_rsp_if.source          rsp_chan
);
   import cst_pkg::*;

   typedef struct packed {
      kind_type             kind;
      logic [LEN_WIDTH-1:0] size;
      logic [COL_WIDTH-1:0] column;
      err_type              err;
   } tok_type;

   typedef struct packed {
      logic    two;
      tok_type tok1;
      tok_type tok0;
   } entry_type;

   entry_type cur_ff;
   logic      valid_ff;
   logic      idx_ff;
   tok_type   tok;
   logic      last;
   logic      done;

   assign tok  = idx_ff ? cur_ff.tok1 : cur_ff.tok0;
   assign last = (idx_ff == cur_ff.two);
   // group finished or nothing held
   assign done = !valid_ff || (rsp_chan.ready && last);
   assign pop  = done && !empty;

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.token_kind  = tok.kind;
   assign rsp_chan.token_size  = tok.size;
   assign rsp_chan.column      = tok.column;
   assign rsp_chan.error_code  = tok.err;
   assign rsp_chan.last_of_run = last;

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= entry_type'(head_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 1'b0;
      end else begin
         if (pop) begin
            valid_ff <= 1'b1;
            idx_ff   <= 1'b0;
         end else if (done) begin
            valid_ff <= 1'b0;
            idx_ff   <= 1'b0;
         end else if (rsp_chan.ready) begin
            idx_ff <= 1'b1;
         end
      end
   end

   a_index_in_group: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !cur_ff.two) |-> !idx_ff)
      else $error("second token played from single-token group");

   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_chan.ready && !last) |=> (valid_ff && idx_ff))
      else $error("second token of group lost");

endmodule
